/* src/amh_pkg.sv */
// ---------------------------------------------------------------------------
// amh_pkg: shared types and AES-128 helper functions
// Holds the S-box, the round helper functions, and the command and status
// structs that join the controller to the datapath.
// ---------------------------------------------------------------------------
package amh_pkg;

  // AES S-box, entry 0 in the most significant byte.
  localparam logic [0:255][7:0] SBOX = 2048'h637c777bf26b6fc53001672bfed7ab76ca82c97dfa5947f0add4a2af9ca472c0b7fd9326363ff7cc34a5e5f171d8311504c723c31896059a071280e2eb27b27509832c1a1b6e5aa0523bd6b329e32f8453d100ed20fcb15b6acbbe394a4c58cfd0efaafb434d338545f9027f503c9fa851a3408f929d38f5bcb6da2110fff3d2cd0c13ec5f974417c4a77e3d645d197360814fdc222a908846eeb814de5e0bdbe0323a0a4906245cc2d3ac629195e479e7c8376d8dd54ea96c56f4ea657aae08ba78252e1ca6b4c6e8dd741f4bbd8b8a703eb5664803f60e613557b986c11d9ee1f8981169d98e949b1e87e9ce5528df8ca1890dbfe6426841992d0fb054bb16;

  localparam int unsigned NumRounds = 10;

  // Controller states, one-hot.
  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_START     = 13'b0000000000010,
    S_PRE_WAIT  = 13'b0000000000100,
    S_BYTE      = 13'b0000000001000,
    S_BLK_GO    = 13'b0000000010000,
    S_BLK_WAIT  = 13'b0000000100000,
    S_PAD       = 13'b0000001000000,
    S_PAD_CHK   = 13'b0000010000000,
    S_FIN_WAIT  = 13'b0000100000000,
    S_TAIL      = 13'b0001000000000,
    S_TAIL_GO   = 13'b0010000000000,
    S_TAIL_WAIT = 13'b0100000000000,
    S_RESULT    = 13'b1000000000000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input transaction
    logic prefix;    // start a message and hash the length prefix
    logic step;      // consume one message byte
    logic absorb;    // hash the block buffer
    logic pad;       // place the padding byte
    logic tail;      // place the length tail bytes
    logic load_out;  // load the result register
    logic err;       // result is the zero-length error
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rem_zero;
    logic rem_one;
    logic len_zero;
    logic lb_zero;
    logic pos_last;
    logic need_two;
    logic aes_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // SubBytes followed by ShiftRows; byte i sits at bits [127-8i -: 8].
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127 - 8 * (w + 4 * c) -: 8] = SBOX[s[127 - 8 * (w + 4 * ((c + w) % 4)) -: 8]];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      r[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      r[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      r[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      r[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return r;
  endfunction

  // One step of the AES-128 key expansion.
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
    logic [7:0] k [16];
    logic [7:0] t [4];
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      k[i] = rk[127 - 8 * i -: 8];
    end
    t[0] = SBOX[k[13]] ^ rcon;
    t[1] = SBOX[k[14]];
    t[2] = SBOX[k[15]];
    t[3] = SBOX[k[12]];
    for (int i = 0; i < 4; i++) begin
      k[i] = k[i] ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      k[i] = k[i] ^ k[i - 4];
    end
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = k[i];
    end
    return r;
  endfunction

  // Byte reversal of a 64-bit word.
  function automatic logic [63:0] byte_swap(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[63 - 8 * i -: 8] = v[8 * i +: 8];
    end
    return r;
  endfunction

endpackage

/* src/amh_aes.sv */
// ---------------------------------------------------------------------------
// amh_aes: iterative AES-128 with the MMO feed-forward
// One round per cycle with the key expanded on the fly. The result is the
// ciphertext XORed with the input block.
// ---------------------------------------------------------------------------
module amh_aes
  import amh_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] blk,
  input  logic [127:0] key,
  output logic         done,
  output logic [127:0] result
);

  logic [127:0] st;
  logic [127:0] rk;
  logic [127:0] blk_r;
  logic [7:0]   rcon;
  logic [3:0]   rnd;
  logic         busy;
  logic [127:0] rk_next;
  logic [127:0] ss;
  logic         last_round;

  // Round function.
  assign rk_next    = key_next(rk, rcon);
  assign ss         = sub_shift(st);
  assign last_round = (rnd == 4'(NumRounds));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_round) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // State and key registers.
  always_ff @(posedge clk) begin
    if (start) begin
      st    <= blk ^ key;
      rk    <= key;
      blk_r <= blk;
      rcon  <= 8'h01;
      rnd   <= 4'd1;
    end else if (busy) begin
      st   <= (last_round ? ss : mix_columns(ss)) ^ rk_next;
      rk   <= rk_next;
      rcon <= xtime(rcon);
      rnd  <= rnd + 4'd1;
    end
  end

  assign result = st ^ blk_r;

endmodule

/* src/amh_dp.sv */
// ---------------------------------------------------------------------------
// amh_dp: hash datapath
// Holds the chaining value, block buffer, byte position, length and byte
// count, the AES unit and the result register.
// ---------------------------------------------------------------------------
module amh_dp
  import amh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  data_byte,
  input  logic [63:0] msg_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low
);

  logic [7:0]   cap_data;
  logic [63:0]  cap_len;
  logic [63:0]  len;
  logic [60:0]  rem;
  logic [3:0]   pos;
  logic [127:0] chain;
  logic [127:0] blkbuf;
  logic [127:0] blkbuf_next;
  logic [61:0]  cnt_sum;
  logic [60:0]  cnt;
  logic [63:0]  lenp;
  logic         lenp_16;
  logic         lenp_32;
  logic [6:0]   used;
  logic [7:0]   pad_byte;
  logic [15:0]  pad_wide;
  logic [7:0]   wbyte;
  logic         wr_en;
  logic         aes_start;
  logic [127:0] aes_blk;
  logic [127:0] aes_key;
  logic         aes_done;
  logic [127:0] aes_res;

  // Byte count of the message, saturated to the counter width.
  assign cnt_sum = {1'b0, cap_len[63:3]} + {61'd0, (cap_len[2:0] != 3'd0)};
  assign cnt     = cnt_sum[61] ? '1 : cnt_sum[60:0];

  // Tail format selection.
  assign lenp    = len + 64'd128;
  assign lenp_16 = (lenp[63:16] == 48'd0);
  assign lenp_32 = (lenp[63:32] == 32'd0);
  assign used    = len[6:0];

  // Padding byte: data bits moved to the top, then the marker bit.
  assign pad_wide = {cap_data, 8'h00} >> len[2:0];
  assign pad_byte = pad_wide[7:0] | (8'h80 >> len[2:0]);

  // Status toward the controller.
  always_comb begin
    stat.rem_zero = (rem == '0);
    stat.rem_one  = (rem == 61'd1);
    stat.len_zero = (cap_len == 64'd0);
    stat.lb_zero  = (len[2:0] == 3'd0);
    stat.pos_last = (pos == 4'hf);
    if (lenp_16) begin
      stat.need_two = (used >= 7'd112);
    end else if (lenp_32) begin
      stat.need_two = (used >= 7'd80);
    end else begin
      stat.need_two = (used >= 7'd16);
    end
    stat.aes_done = aes_done;
    stat.out_free = !out_valid || !out_stall;
  end

  // Byte write into the block buffer.
  assign wr_en = (cmd.step && (!stat.rem_one || stat.lb_zero)) || cmd.pad;
  assign wbyte = cmd.pad ? pad_byte : cap_data;

  always_comb begin
    blkbuf_next = blkbuf;
    if (aes_done || cmd.prefix) begin
      blkbuf_next = '0;
    end else if (wr_en) begin
      for (int i = 0; i < 16; i++) begin
        if (pos == 4'(i)) begin
          blkbuf_next[127 - 8 * i -: 8] = wbyte;
        end
      end
    end else if (cmd.tail) begin
      if (lenp_16) begin
        blkbuf_next[15:0] = lenp[15:0];
      end else if (lenp_32) begin
        blkbuf_next[31:0] = lenp[31:0];
      end else begin
        blkbuf_next[63:0] = len;
      end
    end
  end

  // Control registers of the message.
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      pos <= '0;
    end else begin
      if (cmd.prefix) begin
        rem <= cnt;
        pos <= '0;
      end else if (cmd.step) begin
        rem <= rem - 61'd1;
        if (wr_en) begin
          pos <= pos + 4'd1;
        end
      end else if (cmd.tail) begin
        pos <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_data <= data_byte;
      cap_len  <= msg_bits;
    end
    if (cmd.prefix) begin
      len <= cap_len;
    end
    if (cmd.prefix) begin
      chain <= '0;
    end else if (aes_done) begin
      chain <= aes_res;
    end
    blkbuf <= blkbuf_next;
  end

  // Block cipher: the prefix uses a zero key, later blocks the chain.
  assign aes_start = cmd.prefix || cmd.absorb;
  assign aes_blk   = cmd.prefix ? {byte_swap(cap_len), 64'd0} : blkbuf;
  assign aes_key   = cmd.prefix ? 128'd0 : chain;

  amh_aes u_aes (
    .clk    (clk),
    .rst    (rst),
    .start  (aes_start),
    .blk    (aes_blk),
    .key    (aes_key),
    .done   (aes_done),
    .result (aes_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= cmd.err;
      digest_high <= cmd.err ? 64'd0 : chain[127:64];
      digest_low  <= cmd.err ? 64'd0 : chain[63:0];
    end
  end

endmodule

/* src/amh_ctrl.sv */
// ---------------------------------------------------------------------------
// amh_ctrl: hash controller
// Sequences prefix, byte collection, block hashing, padding and the tail,
// and hands the digest, or the zero-length error, to the result register.
// ---------------------------------------------------------------------------
module amh_ctrl
  import amh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   err;
  logic   err_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      err   <= err_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    err_next   = err;
    cmd        = '0;
    cmd.err    = err;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (!stat.rem_zero) begin
          state_next = S_BYTE;
        end else if (stat.len_zero) begin
          err_next   = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.prefix = 1'b1;
          state_next = S_PRE_WAIT;
        end
      end
      S_PRE_WAIT: begin
        if (stat.aes_done) begin
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.step = 1'b1;
        if ((!stat.rem_one || stat.lb_zero) && stat.pos_last) begin
          state_next = S_BLK_GO;
        end else if (stat.rem_one) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_BLK_GO: begin
        cmd.absorb = 1'b1;
        state_next = S_BLK_WAIT;
      end
      S_BLK_WAIT: begin
        if (stat.aes_done) begin
          state_next = stat.rem_zero ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        cmd.pad    = 1'b1;
        state_next = S_PAD_CHK;
      end
      S_PAD_CHK: begin
        if (stat.need_two) begin
          cmd.absorb = 1'b1;
          state_next = S_FIN_WAIT;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_FIN_WAIT: begin
        if (stat.aes_done) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = S_TAIL_GO;
      end
      S_TAIL_GO: begin
        cmd.absorb = 1'b1;
        state_next = S_TAIL_WAIT;
      end
      S_TAIL_WAIT: begin
        if (stat.aes_done) begin
          err_next   = 1'b0;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          err_next     = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/aes_mmo_hash_core.sv */
// ---------------------------------------------------------------------------
// aes_mmo_hash_core: AES-128 Matyas-Meyer-Oseas hash
// Streams message bytes and returns a 128-bit digest on the last byte.
// ---------------------------------------------------------------------------
// Each input transaction carries one message byte; msg_bits is read only on
// the first byte of a message. A byte that fills a 16-byte block also waits
// for the AES unit, which runs one round per clock. The first byte of a
// message also hashes the length prefix. The last byte adds the padding and
// tail work, with two final blocks when they are needed, and waits while an
// earlier digest still sits in the result register. A zero-length message
// returns one transaction with status 1 and a zero digest. The result sits in
// an output register, so the next message may start while a digest waits to
// be taken.
module aes_mmo_hash_core
  import amh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic [63:0] msg_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller.
  amh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  amh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .data_byte   (data_byte),
    .msg_bits    (msg_bits),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .digest_high (digest_high),
    .digest_low  (digest_low)
  );

endmodule

/* sim/aes_mmo_hash_core_tb.sv */
// ---------------------------------------------------------------------------
// aes_mmo_hash_core_tb: self-checking testbench for the AES-MMO hash core
// Streams whole messages into the core with random gaps and output stalls.
// A software copy of the hash predicts each digest, and a scoreboard checks
// every result transaction against it field by field.
// ---------------------------------------------------------------------------
module aes_mmo_hash_core_tb;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned RandomItems = 900;
  localparam logic [63:0] ByteCountMax = 64'h1FFF_FFFF_FFFF_FFFF;

  // Expected digest transaction.
  typedef struct {
    bit        status;
    bit [63:0] high;
    bit [63:0] low;
  } digest_t;

  // Digest predictor and checker. Byte i of a block sits at [127-8i -: 8].
  class digest_scoreboard;
    digest_t   pending[$];
    int        errors;
    bit [7:0]  sbox[256];
    bit [127:0] chain;
    bit [127:0] block;
    bit [3:0]  pos;
    bit [63:0] length;
    bit [63:0] remaining;

    function new();
      bit [7:0] inv;
      bit [7:0] b;
      for (int a = 0; a < 256; a++) begin
        inv = 8'd1;
        for (int e = 0; e < 254; e++) inv = gmul(inv, a[7:0]);
        b = inv;
        sbox[a] = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
                  ^ {b[3:0], b[7:4]} ^ 8'h63;
      end
      errors = 0;
      chain = '0;
      block = '0;
      pos = '0;
      length = '0;
      remaining = '0;
    endfunction

    function bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
      bit [8:0] x;
      bit [7:0] r;
      x = {1'b0, a};
      r = '0;
      for (int i = 0; i < 8; i++) begin
        if (b[i]) r ^= x[7:0];
        x = x << 1;
        if (x[8]) x ^= 9'h11b;
      end
      return r;
    endfunction

    function bit [127:0] encrypt(bit [127:0] pt, bit [127:0] key);
      bit [7:0] s[16];
      bit [7:0] k[16];
      bit [7:0] t[16];
      bit [7:0] w[4];
      bit [7:0] a0, a1, a2, a3;
      bit [7:0] rcon;
      bit [127:0] r;
      rcon = 8'h01;
      for (int i = 0; i < 16; i++) begin
        k[i] = key[127 - 8 * i -: 8];
        s[i] = pt[127 - 8 * i -: 8] ^ k[i];
      end
      for (int round = 1; round <= 10; round++) begin
        // SubBytes and ShiftRows.
        for (int c = 0; c < 4; c++)
          for (int rw = 0; rw < 4; rw++)
            t[rw + 4 * c] = sbox[s[rw + 4 * ((c + rw) % 4)]];
        s = t;
        if (round < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
            s[4 * c]     = gmul(a0, 2) ^ gmul(a1, 3) ^ a2 ^ a3;
            s[4 * c + 1] = a0 ^ gmul(a1, 2) ^ gmul(a2, 3) ^ a3;
            s[4 * c + 2] = a0 ^ a1 ^ gmul(a2, 2) ^ gmul(a3, 3);
            s[4 * c + 3] = gmul(a0, 3) ^ a1 ^ a2 ^ gmul(a3, 2);
          end
        end
        // Next round key.
        w[0] = sbox[k[13]] ^ rcon;
        w[1] = sbox[k[14]];
        w[2] = sbox[k[15]];
        w[3] = sbox[k[12]];
        for (int i = 0; i < 4; i++) k[i] ^= w[i];
        for (int i = 4; i < 16; i++) k[i] ^= k[i - 4];
        rcon = gmul(rcon, 2);
        for (int i = 0; i < 16; i++) s[i] ^= k[i];
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
      return r;
    endfunction

    function void absorb(bit [127:0] blk);
      chain = encrypt(blk, chain) ^ blk;
    endfunction

    // Padding is in place; add the length tail and hash the final blocks.
    function void close_message();
      bit [63:0] lenp;
      bit [63:0] val;
      int unsigned used, thr, first;
      lenp = length + 64'd128;
      used = length[6:0];
      if (lenp < 64'd65536) begin
        thr = 112; first = 14; val = lenp;
      end else if (lenp < 64'h1_0000_0000) begin
        thr = 80; first = 12; val = lenp;
      end else begin
        thr = 16; first = 8; val = length;
      end
      for (int j = pos + 1; j < 16; j++) block[127 - 8 * j -: 8] = 8'h00;
      if (used >= thr) begin
        absorb(block);
        block = '0;
      end
      for (int j = first; j < 16; j++) block[127 - 8 * j -: 8] = val >> (8 * (15 - j));
      absorb(block);
    endfunction

    // Notes one accepted input transaction and predicts its result.
    function void note_input(bit [7:0] data, bit [63:0] bits);
      bit [127:0] pre;
      bit [63:0] cnt;
      bit [2:0] lb;
      digest_t d;
      if (remaining == 0) begin
        if (bits == 0) begin
          d.status = 1'b1; d.high = '0; d.low = '0;
          pending.push_back(d);
          return;
        end
        length = bits;
        chain = '0;
        pre = '0;
        for (int j = 0; j < 8; j++) pre[127 - 8 * j -: 8] = bits >> (8 * j);
        absorb(pre);
        block = '0;
        pos = '0;
        cnt = (bits >> 3) + (bits[2:0] != 0);
        if (cnt > ByteCountMax) cnt = ByteCountMax;
        remaining = cnt;
      end
      remaining--;
      lb = length[2:0];
      if (remaining > 0 || lb == 0) begin
        block[127 - 8 * pos -: 8] = data;
        pos++;
        if (pos == 0) begin
          absorb(block);
          block = '0;
        end
      end
      if (remaining > 0) return;
      // A partial last byte keeps only its low data bits, moved to the top.
      if (lb == 0) block[127 - 8 * pos -: 8] = 8'h80;
      else block[127 - 8 * pos -: 8] = (data << (8 - lb)) | (8'h80 >> lb);
      close_message();
      d.status = 1'b0; d.high = chain[127:64]; d.low = chain[63:0];
      pending.push_back(d);
      block = '0;
      pos = '0;
    endfunction

    // Checks one accepted result transaction against the oldest prediction.
    function void check_result(bit st, bit [63:0] hi, bit [63:0] lo);
      digest_t d;
      if (pending.size() == 0) begin
        $error("unexpected result transaction: status %0d", st);
        errors++;
        return;
      end
      d = pending.pop_front();
      if (st !== d.status) begin
        $error("status: expected %0d, got %0d", d.status, st); errors++;
      end
      if (hi !== d.high) begin
        $error("digest_high: expected %h, got %h", d.high, hi); errors++;
      end
      if (lo !== d.low) begin
        $error("digest_low: expected %h, got %h", d.low, lo); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic [63:0] msg_bits;
  logic        out_valid;
  logic        out_stall;
  logic        status;
  logic [63:0] digest_high;
  logic [63:0] digest_low;

  digest_scoreboard hash_sb;
  bit quiet;
  int unsigned idle_cycles;
  int unsigned items_sent;

  aes_mmo_hash_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .msg_bits(msg_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .digest_high(digest_high), .digest_low(digest_low)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Drives one byte transaction; entered and left at a falling edge.
  task automatic push_byte(input bit [7:0] d, input bit [63:0] b);
    in_valid <= 1'b1;
    data_byte <= d;
    msg_bits <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    hash_sb.note_input(d, b);
    items_sent++;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Sends a whole message of len_bits bits; later bytes carry junk lengths.
  task automatic send_message(input bit [63:0] len_bits);
    longint unsigned n;
    n = (len_bits >> 3) + (len_bits[2:0] != 0);
    if (n == 0) n = 1;
    for (longint unsigned i = 0; i < n; i++)
      push_byte(8'($urandom), (i == 0) ? len_bits : {$urandom, $urandom});
  endtask

  // Result side: random stall bursts, then checks on accepted transactions.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      hash_sb.check_result(status, digest_high, digest_low);
  end

  // Watchdog on cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    bit [63:0] len_bits;
    hash_sb = new();
    quiet = 1'b0;
    idle_cycles = 0;
    items_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    msg_bits = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero length, partial bytes, the one- and two-block tails.
    send_message(64'd0);
    send_message(64'd1);
    send_message(64'd7);
    send_message(64'd8);
    send_message(64'd0);
    send_message(64'd111);
    send_message(64'd112);
    send_message(64'd127);
    send_message(64'd128);
    send_message(64'd129);
    send_message(64'd247);

    // Random messages, mostly short; the last part runs without idling.
    while (items_sent < RandomItems) begin
      case ($urandom_range(0, 19))
        0: len_bits = 0;
        1, 2: len_bits = 64'($urandom_range(1, 16));
        default: len_bits = 64'($urandom_range(1, 400));
      endcase
      if (items_sent > RandomItems * 4 / 5) quiet = 1'b1;
      send_message(len_bits);
    end
    in_valid <= 1'b0;

    while (hash_sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (hash_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
